/* rtl/core/sbe_pkg.sv */
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, character codes and the four-valued combine function of the
// symbolic boolean expression evaluator.
// ----------------------------------------------------------------------------
package sbe_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [1:0]       sym_t;

	// value codes
	localparam sym_t V_ZERO = 2'd0;
	localparam sym_t V_ONE  = 2'd1;
	localparam sym_t V_SYM  = 2'd2;
	localparam sym_t V_NSYM = 2'd3;

	// operator codes
	localparam sym_t OP_AND = 2'd0;
	localparam sym_t OP_OR  = 2'd1;
	localparam sym_t OP_XOR = 2'd2;

	// ASCII characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SYM   = 8'h78;
	localparam logic [7:0] CH_NSYM  = 8'h58;
	localparam logic [7:0] CH_AND   = 8'h26;
	localparam logic [7:0] CH_OR    = 8'h7C;
	localparam logic [7:0] CH_XOR   = 8'h5E;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// per-cycle command to every cell of a stack
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	// a: value that stays on the stack, b: popped value
	function automatic sym_t combine(sym_t a, sym_t opc, sym_t b);
		sym_t p;
		sym_t q;
		sym_t r;
		p = a;
		q = b;
		if (a == V_ZERO || a == V_ONE) begin
			p = b;
			q = a;
		end
		case (opc)
			OP_AND: begin
				if (q == V_ZERO)     r = V_ZERO;
				else if (q == V_ONE) r = p;
				else                 r = (p != q) ? V_ZERO : p;
			end
			OP_OR: begin
				if (q == V_ZERO)     r = p;
				else if (q == V_ONE) r = V_ONE;
				else                 r = (p != q) ? V_ONE : p;
			end
			default: begin
				if (q == V_ZERO)     r = p;
				else if (q == V_ONE) r = p ^ 2'd1;
				else                 r = (p != q) ? V_ONE : V_ZERO;
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/sbe_char_if.sv */
// ----------------------------------------------------------------------------
// sbe_char_if
// Character channel: one expression character and its end marker.
// ----------------------------------------------------------------------------
interface sbe_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* rtl/core/sbe_result_if.sv */
// ----------------------------------------------------------------------------
// sbe_result_if
// Result channel: final value of one expression and its status.
// ----------------------------------------------------------------------------
interface sbe_result_if;
	logic       valid;
	logic       ready;
	logic       depends_on_x;
	logic [1:0] final_value;
	logic       parse_error;

	modport source (output valid, output depends_on_x, output final_value,
		output parse_error, input ready);
	modport sink   (input valid, input depends_on_x, input final_value,
		input parse_error, output ready);
endinterface

/* rtl/core/symbolic_bool_expr_stack_eval.sv */
// ----------------------------------------------------------------------------
// symbolic_bool_expr_stack_eval
// Evaluates fully parenthesized boolean expressions over 0, 1, x and X
// with a value stack and an operator stack, one character per transfer.
// ----------------------------------------------------------------------------
//
//  port     | role   | payload                                  | transfer
//  ---------+--------+------------------------------------------+-------------
//  chars    | sink   | char_code[7:0], last                     | valid & ready
//  result   | source | depends_on_x, final_value[1:0], parse_err| valid & ready
//
// One character is taken every cycle unless the output register stalls the
// channel; each updates the stacks as it is taken. The result of a
// character flagged last appears in the output register in the cycle after
// its transfer. chars.ready drops only while that register holds an untaken
// result and result.ready is low.
// arst_n clears the stack counts, the error flag and the output valid.
// ----------------------------------------------------------------------------
module symbolic_bool_expr_stack_eval (
	input  logic               clk,
	input  logic               arst_n,
	sbe_char_if.sink           chars,
	sbe_result_if.source       result
);

	localparam sbe_pkg::cnt_t DEPTH_C = sbe_pkg::cnt_t'(sbe_pkg::STACK_DEPTH);
	localparam sbe_pkg::cnt_t ONE_C   = sbe_pkg::cnt_t'(1);
	localparam sbe_pkg::cnt_t TWO_C   = sbe_pkg::cnt_t'(2);

	// stack fill counts and sticky error
	sbe_pkg::cnt_t vcnt_q;
	sbe_pkg::cnt_t ocnt_q;
	logic          err_q;

	// output register
	logic          res_valid_q;
	logic          res_dep_q;
	sbe_pkg::sym_t res_val_q;
	logic          res_err_q;

	logic          in_xfer;
	logic          is_val;
	logic          is_op;
	logic          is_close;
	sbe_pkg::sym_t val_code;
	sbe_pkg::sym_t op_code;

	logic          v_full;
	logic          o_full;
	logic          can_close;
	logic          do_vpush;
	logic          do_opush;
	logic          do_pop;
	logic          err_hit;

	sbe_pkg::stk_cmd_t v_cmd;
	sbe_pkg::stk_cmd_t o_cmd;
	sbe_pkg::sym_t     v_top;
	sbe_pkg::sym_t     v_next;
	sbe_pkg::sym_t     o_top;
	sbe_pkg::sym_t     o_next;
	sbe_pkg::sym_t     comb_val;

	sbe_pkg::cnt_t     vcnt_nx;
	sbe_pkg::cnt_t     ocnt_nx;
	sbe_pkg::sym_t     top_nx;
	logic              err_nx;
	sbe_pkg::sym_t     fin_val;

	// accept whenever the output register is free or being emptied
	assign chars.ready = !res_valid_q || result.ready;
	assign in_xfer     = chars.valid && chars.ready;

	// classify the character
	always_comb begin
		is_val   = 1'b0;
		is_op    = 1'b0;
		is_close = 1'b0;
		val_code = sbe_pkg::V_ZERO;
		op_code  = sbe_pkg::OP_AND;
		case (chars.char_code)
			sbe_pkg::CH_ZERO:  begin is_val = 1'b1; val_code = sbe_pkg::V_ZERO; end
			sbe_pkg::CH_ONE:   begin is_val = 1'b1; val_code = sbe_pkg::V_ONE;  end
			sbe_pkg::CH_SYM:   begin is_val = 1'b1; val_code = sbe_pkg::V_SYM;  end
			sbe_pkg::CH_NSYM:  begin is_val = 1'b1; val_code = sbe_pkg::V_NSYM; end
			sbe_pkg::CH_AND:   begin is_op  = 1'b1; op_code  = sbe_pkg::OP_AND; end
			sbe_pkg::CH_OR:    begin is_op  = 1'b1; op_code  = sbe_pkg::OP_OR;  end
			sbe_pkg::CH_XOR:   begin is_op  = 1'b1; op_code  = sbe_pkg::OP_XOR; end
			sbe_pkg::CH_CLOSE: begin is_close = 1'b1; end
			default: ;
		endcase
	end

	assign v_full    = (vcnt_q == DEPTH_C);
	assign o_full    = (ocnt_q == DEPTH_C);
	assign can_close = (vcnt_q >= TWO_C) && (ocnt_q >= ONE_C);

	// a push onto a full stack is dropped, a close without operands is ignored
	assign do_vpush = in_xfer && is_val && !v_full;
	assign do_opush = in_xfer && is_op && !o_full;
	assign do_pop   = in_xfer && is_close && can_close;
	assign err_hit  = (is_val && v_full) || (is_op && o_full) || (is_close && !can_close);

	assign v_cmd = '{push: do_vpush, pop: do_pop};
	assign o_cmd = '{push: do_opush, pop: do_pop};

	// the value below the top stays, the top is popped and folded into it
	assign comb_val = sbe_pkg::combine(v_next, o_top, v_top);

	sbe_stack u_val_stack (
		.clk       (clk),
		.cmd       (v_cmd),
		.push_d    (val_code),
		.top_pop_d (comb_val),
		.top       (v_top),
		.next      (v_next)
	);

	sbe_stack u_op_stack (
		.clk       (clk),
		.cmd       (o_cmd),
		.push_d    (op_code),
		.top_pop_d (o_next),
		.top       (o_top),
		.next      (o_next)
	);

	// state as it stands after this character
	always_comb begin
		vcnt_nx = vcnt_q;
		ocnt_nx = ocnt_q;
		top_nx  = v_top;
		if (do_vpush) begin
			vcnt_nx = vcnt_q + ONE_C;
			top_nx  = val_code;
		end else if (do_opush) begin
			ocnt_nx = ocnt_q + ONE_C;
		end else if (do_pop) begin
			vcnt_nx = vcnt_q - ONE_C;
			ocnt_nx = ocnt_q - ONE_C;
			top_nx  = comb_val;
		end
		err_nx = err_q || err_hit;
	end

	// an empty value stack at the end reads as zero with an error
	assign fin_val = (vcnt_nx == '0) ? sbe_pkg::V_ZERO : top_nx;

	// advance counts and error; clear them after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			ocnt_q <= '0;
			err_q  <= 1'b0;
		end else if (in_xfer) begin
			if (chars.last) begin
				vcnt_q <= '0;
				ocnt_q <= '0;
				err_q  <= 1'b0;
			end else begin
				vcnt_q <= vcnt_nx;
				ocnt_q <= ocnt_nx;
				err_q  <= err_nx;
			end
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer && chars.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && chars.last) begin
			res_val_q <= fin_val;
			res_dep_q <= fin_val[1];
			res_err_q <= err_nx || (vcnt_nx == '0);
		end
	end

	assign result.valid        = res_valid_q;
	assign result.depends_on_x = res_dep_q;
	assign result.final_value  = res_val_q;
	assign result.parse_error  = res_err_q;

endmodule

/* rtl/core/sbe_cell.sv */
// ----------------------------------------------------------------------------
// sbe_cell
// One stack entry: load from the neighbor above on push, from below on pop.
// ----------------------------------------------------------------------------
module sbe_cell (
	input  logic             clk,
	input  sbe_pkg::stk_cmd_t cmd,
	input  sbe_pkg::sym_t    push_d,
	input  sbe_pkg::sym_t    pop_d,
	output sbe_pkg::sym_t    q
);

	sbe_pkg::sym_t data_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			data_q <= push_d;
		end else if (cmd.pop) begin
			data_q <= pop_d;
		end
	end

	assign q = data_q;

endmodule

/* rtl/core/sbe_stack.sv */
// ----------------------------------------------------------------------------
// sbe_stack
// Shift stack built as a row of cells; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module sbe_stack (
	input  logic              clk,
	input  sbe_pkg::stk_cmd_t cmd,
	input  sbe_pkg::sym_t     push_d,
	input  sbe_pkg::sym_t     top_pop_d,
	output sbe_pkg::sym_t     top,
	output sbe_pkg::sym_t     next
);

	sbe_pkg::sym_t cell_q [sbe_pkg::STACK_DEPTH];

	for (genvar i = 0; i < sbe_pkg::STACK_DEPTH; i++) begin : g_cell
		sbe_pkg::sym_t from_above;
		sbe_pkg::sym_t from_below;

		if (i == 0) begin : g_top
			assign from_above = push_d;
			assign from_below = top_pop_d;
		end else if (i == sbe_pkg::STACK_DEPTH - 1) begin : g_bottom
			assign from_above = cell_q[i-1];
			assign from_below = sbe_pkg::V_ZERO;
		end else begin : g_mid
			assign from_above = cell_q[i-1];
			assign from_below = cell_q[i+1];
		end

		sbe_cell u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.push_d (from_above),
			.pop_d  (from_below),
			.q      (cell_q[i])
		);
	end

	assign top  = cell_q[0];
	assign next = cell_q[1];

endmodule

/* tb/symbolic_bool_expr_stack_eval_tb.sv */
// ----------------------------------------------------------------------------
// symbolic_bool_expr_stack_eval_tb
// Drives character streams into the expression evaluator and checks every
// result against an in-bench model of the two stacks and the four-valued
// combine. The run covers directed corners, stack overflow and underflow,
// random well-formed expressions with broken ones mixed in, and raw noise.
// The sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module symbolic_bool_expr_stack_eval_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// bytes with no meaning to the block, plus the two field extremes
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] BYTE_NUL = 8'h00;
	localparam logic [7:0] BYTE_TOP = 8'hFF;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int TAIL_CYCLES  = 8;
	localparam int STALL_CYCLES = 120;

	typedef struct packed {
		logic          depends_on_x;
		sbe_pkg::sym_t final_value;
		logic          parse_error;
	} eval_result_t;

	// receiver pacing patterns
	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic clk;
	logic arst_n;

	sbe_char_if   chars_if ();
	sbe_result_if res_if ();

	symbolic_bool_expr_stack_eval dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.result (res_if.source)
	);

	// Expected results, oldest first
	eval_result_t expr_results_due[$];

	// Evaluator state as the block should hold it
	sbe_pkg::sym_t val_stack [sbe_pkg::STACK_DEPTH];
	sbe_pkg::sym_t op_stack  [sbe_pkg::STACK_DEPTH];
	int            val_depth;
	int            op_depth;
	logic          expr_err;

	// Expression under construction
	logic [7:0] expr_buf[$];

	int       mismatches;
	int       items_sent;
	int       cycle_count;
	int       rx_hold_until;
	int       burst_left;
	int       gap_max;
	rx_mode_t rx_mode;

	// ------------------------------------------------------------------------
	// Clock and cycle limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycle_count = 0;

	// Count cycles; abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[symbolic_bool_expr_stack_eval] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Combine the value that stays on the stack (lhs) with the popped one (rhs).
	// Codes with bit 1 set are symbolic: x, or its complement X.
	function automatic sbe_pkg::sym_t fold_values(sbe_pkg::sym_t lhs, sbe_pkg::sym_t opc,
		sbe_pkg::sym_t rhs);
		sbe_pkg::sym_t res;
		if (opc == sbe_pkg::OP_AND) begin
			if (lhs == sbe_pkg::V_ZERO || rhs == sbe_pkg::V_ZERO) res = sbe_pkg::V_ZERO;
			else if (lhs == sbe_pkg::V_ONE)                       res = rhs;
			else if (rhs == sbe_pkg::V_ONE)                       res = lhs;
			else res = (lhs == rhs) ? lhs : sbe_pkg::V_ZERO;
		end else if (opc == sbe_pkg::OP_OR) begin
			if (lhs == sbe_pkg::V_ONE || rhs == sbe_pkg::V_ONE) res = sbe_pkg::V_ONE;
			else if (lhs == sbe_pkg::V_ZERO)                    res = rhs;
			else if (rhs == sbe_pkg::V_ZERO)                    res = lhs;
			else res = (lhs == rhs) ? lhs : sbe_pkg::V_ONE;
		end else begin
			// xor: a constant 1 flips the other side, x flips to X and back
			if (!lhs[1] && !rhs[1]) res = lhs ^ rhs;
			else if (!lhs[1])       res = rhs ^ {1'b0, lhs[0]};
			else if (!rhs[1])       res = lhs ^ {1'b0, rhs[0]};
			else                    res = (lhs == rhs) ? sbe_pkg::V_ZERO : sbe_pkg::V_ONE;
		end
		return res;
	endfunction

	// Advance the evaluator by one transferred character
	function automatic void eval_char(logic [7:0] c, logic is_last);
		sbe_pkg::sym_t opnd;
		sbe_pkg::sym_t opc;
		logic          is_opnd;
		logic          is_op;
		eval_result_t  res;
		is_opnd = 1'b1;
		is_op   = 1'b1;
		opnd    = sbe_pkg::V_ZERO;
		opc     = sbe_pkg::OP_AND;
		case (c)
			sbe_pkg::CH_ZERO: opnd = sbe_pkg::V_ZERO;
			sbe_pkg::CH_ONE:  opnd = sbe_pkg::V_ONE;
			sbe_pkg::CH_SYM:  opnd = sbe_pkg::V_SYM;
			sbe_pkg::CH_NSYM: opnd = sbe_pkg::V_NSYM;
			default:          is_opnd = 1'b0;
		endcase
		case (c)
			sbe_pkg::CH_AND: opc = sbe_pkg::OP_AND;
			sbe_pkg::CH_OR:  opc = sbe_pkg::OP_OR;
			sbe_pkg::CH_XOR: opc = sbe_pkg::OP_XOR;
			default:         is_op = 1'b0;
		endcase

		if (is_opnd) begin
			// drop the push on a full stack
			if (val_depth < sbe_pkg::STACK_DEPTH) begin
				val_stack[val_depth] = opnd;
				val_depth++;
			end else begin
				expr_err = 1'b1;
			end
		end else if (is_op) begin
			if (op_depth < sbe_pkg::STACK_DEPTH) begin
				op_stack[op_depth] = opc;
				op_depth++;
			end else begin
				expr_err = 1'b1;
			end
		end else if (c == sbe_pkg::CH_CLOSE) begin
			// leave both stacks alone when a close finds too little on them
			if (val_depth >= 2 && op_depth >= 1) begin
				val_stack[val_depth - 2] = fold_values(val_stack[val_depth - 2],
					op_stack[op_depth - 1], val_stack[val_depth - 1]);
				val_depth--;
				op_depth--;
			end else begin
				expr_err = 1'b1;
			end
		end

		if (is_last) begin
			// only the top value counts; an empty stack yields 0 and an error
			res.parse_error = expr_err;
			res.final_value = sbe_pkg::V_ZERO;
			if (val_depth >= 1)
				res.final_value = val_stack[val_depth - 1];
			else
				res.parse_error = 1'b1;
			res.depends_on_x = res.final_value[1];
			expr_results_due.push_back(res);
			val_depth = 0;
			op_depth  = 0;
			expr_err  = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	// Compare every transfer on the result channel with the oldest expectation
	always @(posedge clk) begin
		eval_result_t due;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expr_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, got %0d/%0d/%0d",
					$time, res_if.depends_on_x, res_if.final_value, res_if.parse_error);
			end else begin
				due = expr_results_due.pop_front();
				if (res_if.final_value !== due.final_value) begin
					mismatches++;
					$display("%0t: final_value expected %0d got %0d",
						$time, due.final_value, res_if.final_value);
				end
				if (res_if.depends_on_x !== due.depends_on_x) begin
					mismatches++;
					$display("%0t: depends_on_x expected %0d got %0d",
						$time, due.depends_on_x, res_if.depends_on_x);
				end
				if (res_if.parse_error !== due.parse_error) begin
					mismatches++;
					$display("%0t: parse_error expected %0d got %0d",
						$time, due.parse_error, res_if.parse_error);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall on its own pattern, or hold off completely while a
	// long stall is requested
	// ------------------------------------------------------------------------
	initial begin
		logic [1:0] rx_phase;
		rx_phase = 2'd0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_phase = rx_phase + 2'd1;
			if (cycle_count < rx_hold_until) begin
				res_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY: res_if.ready <= 1'b1;
					RX_RANDOM: res_if.ready <= 1'($urandom_range(1, 0));
					RX_SPARSE: res_if.ready <= (rx_phase == 2'd3);
					default:   res_if.ready <= ($urandom_range(7, 0) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Offer one character and hold it until it transfers; open a random gap
	// whenever a burst runs out
	task automatic send_char(input logic [7:0] c, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(gap_max, 0);
			burst_left = $urandom_range(12, 1);
			if (gap != 0) begin
				chars_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		chars_if.last      <= is_last;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		eval_char(c, is_last);
		items_sent++;
	endtask

	// Send the buffered expression, flagging its final character
	task automatic send_expr();
		for (int i = 0; i < expr_buf.size(); i++)
			send_char(expr_buf[i], i == expr_buf.size() - 1);
	endtask

	// Drop valid and wait until every expected result has arrived
	task automatic settle_results();
		chars_if.valid <= 1'b0;
		while (expr_results_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(3, 0))
			0:       return sbe_pkg::CH_ZERO;
			1:       return sbe_pkg::CH_ONE;
			2:       return sbe_pkg::CH_SYM;
			default: return sbe_pkg::CH_NSYM;
		endcase
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(2, 0))
			0:       return sbe_pkg::CH_AND;
			1:       return sbe_pkg::CH_OR;
			default: return sbe_pkg::CH_XOR;
		endcase
	endfunction

	// Append a random fully parenthesized expression of at most depth levels
	function automatic void build_expr(int depth);
		if (depth == 0 || $urandom_range(3, 0) == 0) begin
			expr_buf.push_back(pick_operand());
		end else begin
			expr_buf.push_back(CH_OPEN);
			build_expr(depth - 1);
			expr_buf.push_back(pick_operator());
			build_expr(depth - 1);
			expr_buf.push_back(sbe_pkg::CH_CLOSE);
		end
	endfunction

	// Pick a new receiver pattern and sender gap length; a third of the time
	// the sender runs without gaps
	function automatic void set_pacing();
		rx_mode = rx_mode_t'($urandom_range(3, 0));
		gap_max = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Each operator once (AND on the pair x, X), a close with nothing to pop, an empty
	// value stack at the end, values left below the top, both byte extremes.
	// Run with no idling on either side.
	task automatic test_directed();
		rx_mode = RX_STEADY;
		gap_max = 0;
		expr_buf = '{CH_OPEN, sbe_pkg::CH_SYM, sbe_pkg::CH_AND, sbe_pkg::CH_NSYM,
			sbe_pkg::CH_CLOSE};
		send_expr();
		expr_buf = '{CH_OPEN, sbe_pkg::CH_ONE, sbe_pkg::CH_OR, sbe_pkg::CH_SYM,
			sbe_pkg::CH_CLOSE};
		send_expr();
		expr_buf = '{CH_OPEN, sbe_pkg::CH_NSYM, sbe_pkg::CH_XOR, sbe_pkg::CH_ONE,
			sbe_pkg::CH_CLOSE};
		send_expr();
		expr_buf = '{sbe_pkg::CH_CLOSE, sbe_pkg::CH_ZERO};
		send_expr();
		expr_buf = '{BYTE_TOP};
		send_expr();
		expr_buf = '{BYTE_NUL, sbe_pkg::CH_ONE, sbe_pkg::CH_SYM, sbe_pkg::CH_OR};
		send_expr();
	endtask

	// Fill the stacks to the brim and beyond, then send random closes, at times past the bottom
	task automatic test_stack_limits();
		int n_vals;
		int n_ops;
		int n_close;
		for (int rep = 0; rep < 3; rep++) begin
			set_pacing();
			// first pass fills the value stack exactly, the operator stack to one below
			n_vals  = (rep == 0) ? sbe_pkg::STACK_DEPTH
				: sbe_pkg::STACK_DEPTH + $urandom_range(3, 1);
			n_ops   = (rep == 0) ? sbe_pkg::STACK_DEPTH - 1
				: sbe_pkg::STACK_DEPTH + $urandom_range(3, 1);
			n_close = $urandom_range(sbe_pkg::STACK_DEPTH + 2, 1);
			expr_buf.delete();
			repeat (n_vals)  expr_buf.push_back(pick_operand());
			repeat (n_ops)   expr_buf.push_back(pick_operator());
			repeat (n_close) expr_buf.push_back(sbe_pkg::CH_CLOSE);
			send_expr();
		end
	endtask

	// Mostly well-formed expressions; about one in five broken by a dropped,
	// replaced or inserted byte
	task automatic test_random_expressions(input int target);
		int first_item;
		int pos;
		first_item = items_sent;
		while (items_sent - first_item < target) begin
			if ($urandom_range(7, 0) == 0)
				set_pacing();
			expr_buf.delete();
			build_expr($urandom_range(5, 0));
			if ($urandom_range(4, 0) == 0) begin
				pos = $urandom_range(expr_buf.size() - 1, 0);
				case ($urandom_range(2, 0))
					0: begin
						if (expr_buf.size() > 1)
							expr_buf.delete(pos);
					end
					1:       expr_buf[pos] = 8'($urandom_range(255, 0));
					default: expr_buf.insert(pos, 8'($urandom_range(255, 0)));
				endcase
			end
			send_expr();
		end
	endtask

	// Hold the receiver off while short expressions keep coming, so the
	// output register fills and the character channel stalls
	task automatic test_output_stall();
		gap_max       = 0;
		rx_mode       = RX_RANDOM;
		rx_hold_until = cycle_count + STALL_CYCLES;
		repeat (6) begin
			expr_buf.delete();
			build_expr(1);
			send_expr();
		end
	endtask

	// Pause the sender until the result channel has drained, then go on
	task automatic test_drain_pause();
		test_random_expressions(30);
		settle_results();
		repeat (4) @(posedge clk);
		test_random_expressions(30);
	endtask

	// Raw byte stream with last at random
	task automatic test_random_noise(input int count);
		logic [7:0] c;
		set_pacing();
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3, 0))
				0:       c = 8'($urandom_range(255, 0));
				1:       c = pick_operator();
				2:       c = sbe_pkg::CH_CLOSE;
				default: c = pick_operand();
			endcase
			send_char(c, ($urandom_range(7, 0) == 0) || (i == count - 1));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		mismatches    = 0;
		items_sent    = 0;
		rx_hold_until = 0;
		burst_left    = 0;
		gap_max       = 0;
		rx_mode       = RX_STEADY;
		val_depth     = 0;
		op_depth      = 0;
		expr_err      = 1'b0;

		// hold every input at a known value from the start
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= BYTE_NUL;
		chars_if.last      <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_stack_limits();
		test_random_expressions(200);
		test_output_stall();
		test_drain_pause();
		test_random_expressions(150);
		test_random_noise(150);

		// wait out every expectation, then watch for stray results
		settle_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[symbolic_bool_expr_stack_eval] OK");
		else
			$display("[symbolic_bool_expr_stack_eval] ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sbe_pkg.sv
rtl/core/sbe_char_if.sv
rtl/core/sbe_result_if.sv
rtl/core/sbe_cell.sv
rtl/core/sbe_stack.sv
rtl/core/symbolic_bool_expr_stack_eval.sv
tb/symbolic_bool_expr_stack_eval_tb.sv
